// ----- rtl/core/tlr_pkg.sv -----
// ----------------------------------------------------------------------------
// Thick line rasterizer package
// Shared types and fixed widths for the rasterizer, its channels and its
// shared arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tlr_pkg;

  localparam int CRD_W = 16;
  localparam int DIF_W = 17;
  localparam int MAG_W = 16;
  localparam int TH_W  = 10;
  localparam int COL_W = 8;
  localparam int RXY_W = 9;
  localparam int ARG_W = 62;
  localparam int DVS_W = 32;
  localparam int QUO_W = 48;
  localparam int REM_W = 32;
  localparam int PT_W  = 32;
  localparam int NRM_W = 18;

  localparam int DIV_STEPS  = 48;
  localparam int SQRT_STEPS = 31;

  localparam logic [1:0] MODE_CENTER = 2'd0;
  localparam logic [1:0] MODE_SIDE   = 2'd1;
  localparam logic [1:0] MODE_ARROW  = 2'd2;
  localparam logic [1:0] MODE_READ   = 2'd3;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_SKIP = 1'b1;

  typedef struct packed {
    logic [1:0]              mode;
    logic signed [CRD_W-1:0] x_start;
    logic signed [CRD_W-1:0] y_start;
    logic signed [CRD_W-1:0] x_end;
    logic signed [CRD_W-1:0] y_end;
    logic [TH_W-1:0]         thickness;
    logic [COL_W-1:0]        color;
    logic [RXY_W-1:0]        read_x;
    logic [RXY_W-1:0]        read_y;
  } in_word_t;

  typedef struct packed {
    logic [COL_W-1:0] read_data;
    logic             status;
  } out_word_t;

  typedef enum logic {
    OP_DIV,
    OP_SQRT
  } arith_op_t;

  typedef struct packed {
    logic             start;
    arith_op_t        op;
    logic [ARG_W-1:0] a;
    logic [DVS_W-1:0] b;
  } arith_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
    logic [REM_W-1:0] rem;
  } arith_rsp_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_SQRT,
    ST_DIV_NX,
    ST_DIV_NY,
    ST_DIV_SX,
    ST_DIV_SY,
    ST_DIV_T,
    ST_ROW,
    ST_SAMPLE,
    ST_DRAIN,
    ST_READ,
    ST_READ_WAIT,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/core/tlr_if.sv -----
// ----------------------------------------------------------------------------
// Thick line rasterizer channels
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface tlr_in_if;
  logic               valid;
  logic               ready;
  tlr_pkg::in_word_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tlr_out_if;
  logic               valid;
  logic               ready;
  tlr_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/tlr_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tlr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]              rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/tlr_arith.sv -----
// ----------------------------------------------------------------------------
// Shared divide and square root unit
// Restoring division of a 48-bit dividend by a 32-bit divisor, one quotient
// bit per cycle, or integer square root of a 62-bit radicand, one root bit
// per cycle. Both share one compare-and-subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module tlr_arith (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire tlr_pkg::arith_req_t req,
  output tlr_pkg::arith_rsp_t      rsp
);

  import tlr_pkg::*;

  logic             busy_r;
  logic             done_r;
  arith_op_t        op_r;
  logic [5:0]       cnt_r;
  logic [ARG_W-1:0] acc_r;
  logic [DVS_W-1:0] b_r;
  logic [QUO_W-1:0] quo_r;
  logic [REM_W-1:0] rem_r;

  logic [33:0] trial;
  logic [33:0] sub;
  logic [33:0] diff;
  logic        fits;
  logic        last;

  always_comb begin
    unique case (op_r)
      OP_SQRT: begin
        trial = {rem_r[31:0], acc_r[ARG_W-1 -: 2]};
        sub   = {1'b0, quo_r[30:0], 2'b01};
      end
      default: begin
        trial = {1'b0, rem_r[31:0], acc_r[QUO_W-1]};
        sub   = {2'b00, b_r};
      end
    endcase
    diff = trial - sub;
    fits = !diff[33];
    last = (op_r == OP_SQRT) ? (cnt_r == 6'(SQRT_STEPS - 1)) : (cnt_r == 6'(DIV_STEPS - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && last;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && last) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r  <= req.op;
      acc_r <= req.a;
      b_r   <= req.b;
      cnt_r <= '0;
      quo_r <= '0;
      rem_r <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 6'd1;
      quo_r <= {quo_r[QUO_W-2:0], fits};
      rem_r <= fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
      acc_r <= (op_r == OP_SQRT) ? {acc_r[ARG_W-3:0], 2'b00} : {acc_r[ARG_W-2:0], 1'b0};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule

`default_nettype wire

// ----- rtl/core/thick_line_rasterizer.sv -----
// Sequence: a read passes the read and read-wait states; a draw runs its setup
// (one 31-step root and five 48-step divisions in the shared unit), then a row
// state per line step and a sample state per sample, then drain and finish.
// Throughput: one command at a time; one frame-buffer write per in-frame sample.
// Reset: after rst_n the block clears FB_WIDTH*FB_HEIGHT pixels, one per
// cycle, and accepts no command until that pass is over.
// ----------------------------------------------------------------------------
// Thick line rasterizer
// Sequencer and datapath that walk a thick line in half-pixel steps and write
// its samples into an 8-bit frame buffer; also serves pixel reads.
// ----------------------------------------------------------------------------
`default_nettype none

module thick_line_rasterizer #(
  parameter int FB_WIDTH  = 512,
  parameter int FB_HEIGHT = 512
) (
  input wire logic clk,
  input wire logic rst_n,
  tlr_in_if.sink   in_ch,
  tlr_out_if.source out_ch
);

  import tlr_pkg::*;

  localparam int DEPTH = FB_WIDTH * FB_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  state_t state_r, state_nxt;
  logic   started_r, started_nxt;
  logic [AW-1:0] clr_r, clr_nxt;

  logic [1:0]              mode_r, mode_nxt;
  logic signed [CRD_W-1:0] xs_r, xs_nxt, ys_r, ys_nxt, xe_r, xe_nxt, ye_r, ye_nxt;
  logic [TH_W-1:0]         th_r, th_nxt;
  logic [COL_W-1:0]        col_r, col_nxt;
  logic [RXY_W-1:0]        rdx_r, rdx_nxt, rdy_r, rdy_nxt;

  logic signed [DIF_W-1:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic [MAG_W-1:0]        adx_r, adx_nxt, ady_r, ady_nxt, d_r, d_nxt;
  logic [30:0]             root_r, root_nxt;
  logic signed [NRM_W-1:0] nx_r, nx_nxt, ny_r, ny_nxt;
  logic signed [16:0]      qsx_r, qsx_nxt, qsy_r, qsy_nxt;
  logic [MAG_W-1:0]        rsx_r, rsx_nxt, rsy_r, rsy_nxt;
  logic [13:0]             qt_r, qt_nxt;
  logic [MAG_W-1:0]        rt_r, rt_nxt;

  logic signed [PT_W-1:0]  bx_r, bx_nxt, by_r, by_nxt;
  logic [MAG_W-1:0]        bxr_r, bxr_nxt, byr_r, byr_nxt;
  logic signed [15:0]      hq_r, hq_nxt;
  logic [MAG_W-1:0]        ha_r, ha_nxt;
  logic [16:0]             kd_r, kd_nxt;
  logic [12:0]             ju_r, ju_nxt, span_r, span_nxt;
  logic signed [PT_W-1:0]  accx_r, accx_nxt, accy_r, accy_nxt;

  logic                    stg_vld_r, stg_vld_nxt;
  logic signed [15:0]      stg_px_r, stg_px_nxt, stg_py_r, stg_py_nxt;

  logic [COL_W-1:0]        res_data_r, res_data_nxt;
  logic                    res_status_r, res_status_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_word_t               out_word_r, out_word_nxt;

  arith_req_t areq;
  arith_rsp_t arsp;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [COL_W-1:0]  wr_data;
  logic [AW-1:0]     rd_addr;
  logic [COL_W-1:0]  rd_data;
  logic              stg_ok;
  logic              rd_ok;

  logic signed [DIF_W-1:0] dx_c, dy_c;
  logic [MAG_W-1:0]        adx_c, ady_c, d_c;
  logic [32:0]             sq_c;
  logic [16:0]             q17;
  logic [15:0]             h_c;
  logic signed [13:0]      lo_c;
  logic signed [PT_W-1:0]  ptx_c, pty_c;
  logic [13:0]             ju_next_c;
  logic [16:0]             kd_next_c, bsx_c, bsy_c, hs_c;
  logic                    nneg_c;

  tlr_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (areq),
    .rsp   (arsp)
  );

  tlr_ram #(
    .WIDTH (COL_W),
    .DEPTH (DEPTH)
  ) u_fb (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign stg_ok = !stg_px_r[15] && !stg_py_r[15] &&
                  ({16'd0, stg_px_r} < 32'(FB_WIDTH)) &&
                  ({16'd0, stg_py_r} < 32'(FB_HEIGHT));
  assign rd_ok  = ({23'd0, rdx_r} < 32'(FB_WIDTH)) && ({23'd0, rdy_r} < 32'(FB_HEIGHT));
  assign rd_addr = AW'(rdy_r) * AW'(FB_WIDTH) + AW'(rdx_r);

  always_comb begin
    if (state_r == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_r;
      wr_data = '0;
    end else begin
      wr_en   = stg_vld_r && stg_ok;
      wr_addr = AW'(stg_py_r) * AW'(FB_WIDTH) + AW'(stg_px_r);
      wr_data = col_r;
    end
  end

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_word_r;

  always_comb begin
    state_nxt = state_r;  started_nxt = started_r;  clr_nxt = clr_r;
    mode_nxt = mode_r;  xs_nxt = xs_r;  ys_nxt = ys_r;  xe_nxt = xe_r;  ye_nxt = ye_r;
    th_nxt = th_r;  col_nxt = col_r;  rdx_nxt = rdx_r;  rdy_nxt = rdy_r;
    dx_nxt = dx_r;  dy_nxt = dy_r;  adx_nxt = adx_r;  ady_nxt = ady_r;  d_nxt = d_r;
    root_nxt = root_r;  nx_nxt = nx_r;  ny_nxt = ny_r;
    qsx_nxt = qsx_r;  rsx_nxt = rsx_r;  qsy_nxt = qsy_r;  rsy_nxt = rsy_r;
    qt_nxt = qt_r;  rt_nxt = rt_r;
    bx_nxt = bx_r;  by_nxt = by_r;  bxr_nxt = bxr_r;  byr_nxt = byr_r;
    hq_nxt = hq_r;  ha_nxt = ha_r;  kd_nxt = kd_r;  ju_nxt = ju_r;  span_nxt = span_r;
    accx_nxt = accx_r;  accy_nxt = accy_r;
    stg_vld_nxt = 1'b0;  stg_px_nxt = stg_px_r;  stg_py_nxt = stg_py_r;
    res_data_nxt = res_data_r;  res_status_nxt = res_status_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_word_nxt = out_word_r;
    areq.start = 1'b0;  areq.op = OP_DIV;  areq.a = '0;  areq.b = '0;

    dx_c  = DIF_W'(xe_r) - DIF_W'(xs_r);
    dy_c  = DIF_W'(ye_r) - DIF_W'(ys_r);
    adx_c = dx_c[DIF_W-1] ? MAG_W'(-dx_c) : MAG_W'(dx_c);
    ady_c = dy_c[DIF_W-1] ? MAG_W'(-dy_c) : MAG_W'(dy_c);
    d_c   = (adx_c > ady_c) ? adx_c : ady_c;
    sq_c  = {1'b0, 32'(adx_r) * 32'(adx_r)} + {1'b0, 32'(ady_r) * 32'(ady_r)};
    q17   = arsp.quo[16:0];
    nneg_c = 1'b0;

    h_c  = 16'(hq_r - ((ha_r != '0) ? 16'sd1 : 16'sd0));
    lo_c = -$signed({2'b00, h_c[11:0]});

    ptx_c = bx_r + (accx_r >>> 6) + 32'sd65535;
    pty_c = by_r + (accy_r >>> 6) + 32'sd65535;
    ju_next_c = {1'b0, ju_r} + 14'd32;
    kd_next_c = kd_r + 17'd8;
    bsx_c = {1'b0, bxr_r} + {1'b0, rsx_r};
    bsy_c = {1'b0, byr_r} + {1'b0, rsy_r};
    hs_c  = {1'b0, ha_r} + {1'b0, rt_r};

    unique case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_ch.valid) begin
          mode_nxt = in_ch.data.mode;
          xs_nxt = in_ch.data.x_start;  ys_nxt = in_ch.data.y_start;
          xe_nxt = in_ch.data.x_end;    ye_nxt = in_ch.data.y_end;
          th_nxt = in_ch.data.thickness;  col_nxt = in_ch.data.color;
          rdx_nxt = in_ch.data.read_x;  rdy_nxt = in_ch.data.read_y;
          state_nxt = (in_ch.data.mode == MODE_READ) ? ST_READ : ST_SETUP;
        end
      end
      ST_SETUP: begin
        dx_nxt = dx_c;  dy_nxt = dy_c;  adx_nxt = adx_c;  ady_nxt = ady_c;  d_nxt = d_c;
        if (d_c == '0) begin
          res_data_nxt = '0;
          res_status_nxt = STATUS_SKIP;
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT, ST_DIV_NX, ST_DIV_NY, ST_DIV_SX, ST_DIV_SY, ST_DIV_T: begin
        areq.start = !started_r;
        started_nxt = 1'b1;
        unique case (state_r)
          ST_SQRT: begin
            areq.op = OP_SQRT;
            areq.a  = ARG_W'(sq_c) << 28;
          end
          ST_DIV_NX: begin
            areq.a = ARG_W'({ady_r, 30'd0});
            areq.b = DVS_W'(root_r);
          end
          ST_DIV_NY: begin
            areq.a = ARG_W'({adx_r, 30'd0});
            areq.b = DVS_W'(root_r);
          end
          ST_DIV_SX: begin
            areq.a = ARG_W'({adx_r, 15'd0});
            areq.b = DVS_W'(d_r);
          end
          ST_DIV_SY: begin
            areq.a = ARG_W'({ady_r, 15'd0});
            areq.b = DVS_W'(d_r);
          end
          default: begin
            areq.a = ARG_W'({th_r, 4'd0});
            areq.b = DVS_W'(d_r);
          end
        endcase
        if (arsp.done) begin
          started_nxt = 1'b0;
          unique case (state_r)
            ST_SQRT: begin
              root_nxt = arsp.quo[30:0];
              state_nxt = ST_DIV_NX;
            end
            ST_DIV_NX: begin
              nneg_c = (mode_r == MODE_SIDE) ? dy_r[DIF_W-1] : !dy_r[DIF_W-1];
              nx_nxt = nneg_c ? -$signed({1'b0, q17}) : $signed({1'b0, q17});
              state_nxt = ST_DIV_NY;
            end
            ST_DIV_NY: begin
              nneg_c = (mode_r == MODE_SIDE) ? !dx_r[DIF_W-1] : dx_r[DIF_W-1];
              ny_nxt = nneg_c ? -$signed({1'b0, q17}) : $signed({1'b0, q17});
              state_nxt = ST_DIV_SX;
            end
            ST_DIV_SX: begin
              if (!dx_r[DIF_W-1]) begin
                qsx_nxt = $signed(q17);  rsx_nxt = arsp.rem[MAG_W-1:0];
              end else if (arsp.rem[MAG_W-1:0] != '0) begin
                qsx_nxt = $signed(~q17);  rsx_nxt = d_r - arsp.rem[MAG_W-1:0];
              end else begin
                qsx_nxt = -$signed(q17);  rsx_nxt = '0;
              end
              state_nxt = ST_DIV_SY;
            end
            ST_DIV_SY: begin
              if (!dy_r[DIF_W-1]) begin
                qsy_nxt = $signed(q17);  rsy_nxt = arsp.rem[MAG_W-1:0];
              end else if (arsp.rem[MAG_W-1:0] != '0) begin
                qsy_nxt = $signed(~q17);  rsy_nxt = d_r - arsp.rem[MAG_W-1:0];
              end else begin
                qsy_nxt = -$signed(q17);  rsy_nxt = '0;
              end
              state_nxt = ST_DIV_T;
            end
            default: begin
              qt_nxt = arsp.quo[13:0];
              rt_nxt = arsp.rem[MAG_W-1:0];
              bx_nxt = {{4{xs_r[CRD_W-1]}}, xs_r, 12'd0};
              by_nxt = {{4{ys_r[CRD_W-1]}}, ys_r, 12'd0};
              bxr_nxt = '0;  byr_nxt = '0;
              hq_nxt = $signed({5'd0, th_r, 1'b0});
              ha_nxt = '0;
              kd_nxt = '0;
              state_nxt = ST_ROW;
            end
          endcase
        end
      end
      ST_ROW: begin
        ju_nxt = '0;
        if (mode_r == MODE_SIDE) begin
          span_nxt = {1'b0, th_r, 2'b00};
          accx_nxt = '0;
          accy_nxt = '0;
        end else begin
          if (mode_r == MODE_ARROW) begin
            span_nxt = {h_c[11:0], 1'b0};
            accx_nxt = 32'(lo_c) * 32'(nx_r);
            accy_nxt = 32'(lo_c) * 32'(ny_r);
          end else begin
            span_nxt = {1'b0, th_r, 2'b00};
            accx_nxt = -(32'($signed({1'b0, th_r, 1'b0})) * 32'(nx_r));
            accy_nxt = -(32'($signed({1'b0, th_r, 1'b0})) * 32'(ny_r));
          end
        end
        state_nxt = ST_SAMPLE;
      end
      ST_SAMPLE: begin
        stg_vld_nxt = 1'b1;
        stg_px_nxt  = ptx_c[31:16];
        stg_py_nxt  = pty_c[31:16];
        accx_nxt = accx_r + (32'(nx_r) <<< 5);
        accy_nxt = accy_r + (32'(ny_r) <<< 5);
        ju_nxt   = ju_next_c[12:0];
        if (ju_next_c > {1'b0, span_r}) begin
          if (bsx_c >= {1'b0, d_r}) begin
            bxr_nxt = MAG_W'(bsx_c - {1'b0, d_r});
            bx_nxt  = bx_r + 32'(qsx_r) + 32'sd1;
          end else begin
            bxr_nxt = bsx_c[MAG_W-1:0];
            bx_nxt  = bx_r + 32'(qsx_r);
          end
          if (bsy_c >= {1'b0, d_r}) begin
            byr_nxt = MAG_W'(bsy_c - {1'b0, d_r});
            by_nxt  = by_r + 32'(qsy_r) + 32'sd1;
          end else begin
            byr_nxt = bsy_c[MAG_W-1:0];
            by_nxt  = by_r + 32'(qsy_r);
          end
          if (hs_c >= {1'b0, d_r}) begin
            ha_nxt = MAG_W'(hs_c - {1'b0, d_r});
            hq_nxt = hq_r - $signed({2'b00, qt_r}) - 16'sd1;
          end else begin
            ha_nxt = hs_c[MAG_W-1:0];
            hq_nxt = hq_r - $signed({2'b00, qt_r});
          end
          kd_nxt = kd_next_c;
          state_nxt = (kd_next_c <= {1'b0, d_r}) ? ST_ROW : ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        res_data_nxt = '0;
        res_status_nxt = STATUS_DONE;
        state_nxt = ST_FIN;
      end
      ST_READ: begin
        state_nxt = ST_READ_WAIT;
      end
      ST_READ_WAIT: begin
        res_data_nxt = rd_ok ? rd_data : '0;
        res_status_nxt = STATUS_DONE;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_word_nxt.read_data = res_data_r;
          out_word_nxt.status = res_status_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      started_r   <= 1'b0;
      clr_r       <= '0;
      stg_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      started_r   <= started_nxt;
      clr_r       <= clr_nxt;
      stg_vld_r   <= stg_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;  xs_r <= xs_nxt;  ys_r <= ys_nxt;  xe_r <= xe_nxt;  ye_r <= ye_nxt;
    th_r <= th_nxt;  col_r <= col_nxt;  rdx_r <= rdx_nxt;  rdy_r <= rdy_nxt;
    dx_r <= dx_nxt;  dy_r <= dy_nxt;  adx_r <= adx_nxt;  ady_r <= ady_nxt;  d_r <= d_nxt;
    root_r <= root_nxt;  nx_r <= nx_nxt;  ny_r <= ny_nxt;
    qsx_r <= qsx_nxt;  rsx_r <= rsx_nxt;  qsy_r <= qsy_nxt;  rsy_r <= rsy_nxt;
    qt_r <= qt_nxt;  rt_r <= rt_nxt;
    bx_r <= bx_nxt;  by_r <= by_nxt;  bxr_r <= bxr_nxt;  byr_r <= byr_nxt;
    hq_r <= hq_nxt;  ha_r <= ha_nxt;  kd_r <= kd_nxt;  ju_r <= ju_nxt;  span_r <= span_nxt;
    accx_r <= accx_nxt;  accy_r <= accy_nxt;
    stg_px_r <= stg_px_nxt;  stg_py_r <= stg_py_nxt;
    res_data_r <= res_data_nxt;  res_status_r <= res_status_nxt;
    out_word_r <= out_word_nxt;
  end

  a_idle_no_write : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !stg_vld_r)
    else $error("sample write pending while idle");

  a_arith_owner : assert property (@(posedge clk) disable iff (!rst_n)
    arsp.done |-> (state_r == ST_SQRT || state_r == ST_DIV_NX || state_r == ST_DIV_NY ||
                   state_r == ST_DIV_SX || state_r == ST_DIV_SY || state_r == ST_DIV_T))
    else $error("arithmetic result with no owner");

  a_out_from_fin : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result word raised outside the finish state");

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// Thick line rasterizer testbench
// Sends draw and read commands to the rasterizer with random gaps on both
// channels and keeps its own copy of the frame buffer. Every result word is
// checked against a predicted value; read data is predicted from that copy.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import tlr_pkg::*;

  localparam int FB_W = 512;
  localparam int FB_H = 512;

  class pixel_scoreboard;
    byte unsigned frame[FB_W*FB_H];
    out_word_t    pending_results[$];
    int           mismatches;
    int           draws;
    int           reads;
    int           skips;

    function longint floor_div(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q--;
      return q;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned bit_w;
      res = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > v) bit_w >>= 2;
      while (bit_w != 0) begin
        if (v >= res + bit_w) begin
          v -= res + bit_w;
          res = (res >> 1) + bit_w;
        end else begin
          res >>= 1;
        end
        bit_w >>= 2;
      end
      return res;
    endfunction

    function void plot(longint fx, longint fy, byte unsigned c);
      longint px;
      longint py;
      px = -floor_div(-fx, 65536);
      py = -floor_div(-fy, 65536);
      if (px < 0 || py < 0 || px >= FB_W || py >= FB_H) return;
      frame[py*FB_W + px] = c;
    endfunction

    function bit rasterize(in_word_t w);
      longint xs, ys, dx, dy, adx, ady, d, r, nx, ny, th, k, bx, by, lo, span, h, j, u;
      longint unsigned sq;
      xs = longint'(w.x_start);
      ys = longint'(w.y_start);
      dx = longint'(w.x_end) - xs;
      dy = longint'(w.y_end) - ys;
      th = longint'(w.thickness);
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      d = adx > ady ? adx : ady;
      if (d == 0) return STATUS_SKIP;
      sq = longint'(dx*dx + dy*dy) << 28;
      r = longint'(int_sqrt(sq));
      if (r <= 0) r = 1;
      if (w.mode == MODE_SIDE) begin
        nx = (dy * (64'sd1 << 30)) / r;
        ny = (-dx * (64'sd1 << 30)) / r;
      end else begin
        nx = (-dy * (64'sd1 << 30)) / r;
        ny = (dx * (64'sd1 << 30)) / r;
      end
      for (k = 0; 8*k <= d; k++) begin
        bx = xs*4096 + floor_div(8*k*dx*4096, d);
        by = ys*4096 + floor_div(8*k*dy*4096, d);
        if (w.mode == MODE_SIDE) begin
          lo = 0;
          span = 4*th;
        end else begin
          h = (w.mode == MODE_ARROW) ? floor_div(2*th*(d - 8*k), d) : 2*th;
          lo = -h;
          span = 2*h;
        end
        for (j = 0; 32*j <= span; j++) begin
          u = lo + 32*j;
          plot(bx + floor_div(u*nx, 64), by + floor_div(u*ny, 64), w.color);
        end
      end
      return STATUS_DONE;
    endfunction

    function void note_command(in_word_t w);
      out_word_t e;
      e = '0;
      if (w.mode == MODE_READ) begin
        reads++;
        if (w.read_x < FB_W && w.read_y < FB_H) e.read_data = frame[w.read_y*FB_W + w.read_x];
      end else begin
        draws++;
        e.status = rasterize(w);
        if (e.status == STATUS_SKIP) skips++;
      end
      pending_results.push_back(e);
    endfunction

    function void check_result(out_word_t got);
      out_word_t e;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word: data %0d status %0d",
                                       got.read_data, got.status);
        return;
      end
      e = pending_results.pop_front();
      if (got.read_data !== e.read_data || got.status !== e.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected data %0d status %0d, got data %0d status %0d",
                   e.read_data, e.status, got.read_data, got.status);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   no_idle;
  int   last_px;
  int   last_py;
  pixel_scoreboard sb;

  tlr_in_if  in_ch ();
  tlr_out_if out_ch ();

  thick_line_rasterizer i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #200ms;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
    out_ch.ready <= no_idle || ($urandom_range(99) >= 34);
  end

  task automatic send_word(in_word_t w);
    if (!no_idle && $urandom_range(99) < 34) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_command(w);
    if (w.mode != MODE_READ) begin
      last_px = int'(w.x_end) >>> 4;
      last_py = int'(w.y_end) >>> 4;
    end
  endtask

  task automatic draw_line(logic [1:0] m, int xs, int ys, int xe, int ye, int th, int c);
    in_word_t w;
    w = '0;
    w.mode = m;
    w.x_start = 16'(xs);
    w.y_start = 16'(ys);
    w.x_end = 16'(xe);
    w.y_end = 16'(ye);
    w.thickness = 10'(th);
    w.color = 8'(c);
    w.read_x = 9'($urandom);
    w.read_y = 9'($urandom);
    send_word(w);
  endtask

  task automatic read_pixel(int x, int y);
    in_word_t w;
    w = '0;
    w.mode = MODE_READ;
    w.x_start = 16'($urandom);
    w.y_start = 16'($urandom);
    w.x_end = 16'($urandom);
    w.y_end = 16'($urandom);
    w.thickness = 10'($urandom);
    w.color = 8'($urandom);
    w.read_x = 9'(x);
    w.read_y = 9'(y);
    send_word(w);
  endtask

  task automatic read_near_last();
    int x;
    int y;
    x = last_px + $urandom_range(0, 6) - 3;
    y = last_py + $urandom_range(0, 6) - 3;
    if (x < 0) x = 0;
    if (x > FB_W-1) x = FB_W-1;
    if (y < 0) y = 0;
    if (y > FB_H-1) y = FB_H-1;
    read_pixel(x, y);
  endtask

  task automatic random_command();
    int sel;
    int cx;
    int cy;
    int th;
    int reach;
    sel = $urandom_range(99);
    cx = $urandom_range(0, FB_W*16 - 1);
    cy = $urandom_range(0, FB_H*16 - 1);
    if (sel < 12) begin
      read_pixel($urandom_range(0, 511), $urandom_range(0, 511));
    end else if (sel < 30) begin
      read_near_last();
    end else if (sel < 35) begin
      draw_line(2'($urandom_range(0, 2)), cx, cy, cx, cy, $urandom_range(0, 1023), $urandom);
    end else if (sel < 42) begin
      draw_line(2'($urandom_range(0, 2)), $signed(16'($urandom)), $signed(16'($urandom)),
                $signed(16'($urandom)), $signed(16'($urandom)), $urandom_range(0, 15),
                $urandom);
    end else if (sel < 50) begin
      reach = 128;
      draw_line(2'($urandom_range(0, 2)), cx, cy, cx + $urandom_range(0, 2*reach) - reach,
                cy + $urandom_range(0, 2*reach) - reach, $urandom_range(512, 1023),
                $urandom);
    end else begin
      reach = 640;
      th = $urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 64);
      draw_line(2'($urandom_range(0, 2)), cx, cy, cx + $urandom_range(0, 2*reach) - reach,
                cy + $urandom_range(0, 2*reach) - reach, th, $urandom);
    end
  endtask

  initial begin
    int n;
    sb = new();
    no_idle = 1'b0;
    last_px = 0;
    last_py = 0;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    read_pixel(0, 0);
    read_pixel(511, 511);
    draw_line(MODE_CENTER, 100*16, 100*16, 140*16, 120*16, 48, 255);
    read_pixel(120, 110);
    draw_line(MODE_SIDE, 200*16, 50*16, 200*16, 90*16, 40, 17);
    read_pixel(198, 70);
    read_pixel(202, 70);
    draw_line(MODE_ARROW, 300*16, 300*16, 260*16, 340*16, 96, 128);
    read_pixel(300, 300);
    draw_line(MODE_CENTER, 50*16, 50*16, 50*16, 50*16, 80, 9);
    draw_line(MODE_ARROW, 7, 9, 7, 9, 0, 9);
    draw_line(MODE_CENTER, 10*16, 400*16, 60*16, 402*16, 0, 1);
    read_pixel(35, 401);
    draw_line(MODE_ARROW, 400*16, 20*16, 420*16, 40*16, 0, 2);
    draw_line(MODE_CENTER, -32768, -32768, 32767, 32767, 0, 85);
    read_pixel(256, 256);
    draw_line(MODE_SIDE, 32767, -32768, -32768, 32767, 3, 170);
    draw_line(MODE_CENTER, 500*16, 500*16, 515*16, 505*16, 1023, 0);
    read_pixel(511, 511);
    draw_line(MODE_SIDE, 5*16, 5*16, 12*16, 1*16, 1023, 201);
    read_pixel(6, 6);
    draw_line(MODE_ARROW, 240*16, 480*16, 250*16, 470*16, 1023, 66);
    read_pixel(240, 480);

    for (n = 0; n < 118; n++) begin
      no_idle = (n >= 60 && n < 90);
      random_command();
    end
    no_idle = 1'b0;
    in_ch.valid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d draw commands (%0d zero-length) and %0d pixel reads.",
             sb.draws, sb.skips, sb.reads);
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d result words were wrong.", sb.mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
